// ----- rtl/tga_pkg.sv -----
// Package: shared types and constants of the TGA run-length pixel decoder.
`default_nettype none

package tga_pkg;

  localparam int PIXEL_COUNT_BITS_DEF = 24;

  localparam int CFG_TOTAL_W = 24;
  localparam int CFG_BPP_W   = 3;
  localparam int CFG_IDX_W   = 2;

  localparam logic [7:0] RUN_FLAG = 8'h80;
  localparam logic [7:0] RUN_BIAS = 8'd127;

  localparam logic [CFG_BPP_W-1:0] BPP_RESET  = 3'd3;
  localparam logic [CFG_BPP_W-1:0] BPP_ALPHA  = 3'd4;
  localparam logic [2:0]           SIZE_RGB   = 3'd3;
  localparam logic [2:0]           SIZE_RGBA  = 3'd4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BPP   = 2'd0,
    REG_RLE   = 2'd1,
    REG_TOTAL = 2'd2,
    REG_NONE  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_BPP_W-1:0]   bpp;
    logic                   rle;
    logic [CFG_TOTAL_W-1:0] total;
  } cfg_t;

  typedef struct packed {
    logic       over;
    logic       last;
    logic [7:0] repeat_res;
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

endpackage

`default_nettype wire

// ----- rtl/tga_rle_pixel_decoder_unit.sv -----
// Top level of the TGA run-length pixel decoder.
//
// Usage:
//   in_*  : one image-data byte per transaction (tdata), tuser marks the
//           first byte of an image and clears the decoder state.
//   out_* : one decoded pixel per transaction, RGB(A) order, with a repeat
//           count; tlast marks the pixel that completes the image and tuser
//           flags a packet clipped at the image end.
//   cfg_* : register writes (0 pixel size, 1 run-length mode, 2 pixel
//           total); write only while no byte is in flight.
// Throughput: one byte per cycle while in_tready is high. Headers and partial pixels give no pixel.
// Output: a pixel appears on out_* in the cycle after the byte completing it
//   is accepted, held in the single output register.
// Stall: in_tready drops only while the output register is full and
//   out_tready is low; the held pixel stays stable until taken.
// Reset (rst_n low, synchronous): drop any held pixel, return to header
//   expectation and load register defaults (3-byte pixels, run-length on,
//   pixel total 1).
`default_nettype none

module tga_rle_pixel_decoder_unit #(
  parameter int PIXEL_COUNT_BITS = tga_pkg::PIXEL_COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input bytes
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [7:0]                      in_tdata,   // [7:0] data_byte
  input  wire logic                            in_tuser,   // [0] start_image
  // decoded pixels
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [39:32] repeat_res
  output logic [39:0]                          out_tdata,
  output logic                                 out_tlast,  // last_pixel
  output logic                                 out_tuser,  // [0] overrun
  // configuration writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tga_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tga_pkg::CFG_TOTAL_W-1:0] cfg_data
);

  tga_pkg::cfg_t cfg;
  tga_pkg::pix_t dec_pix;
  tga_pkg::pix_t held_pix;
  logic          dec_valid;
  logic          in_take;

  assign cfg_ready = 1'b1;
  assign in_take   = in_tvalid && in_tready;

  tga_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  tga_dec #(
    .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS)
  ) u_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (in_take),
    .data_byte   (in_tdata),
    .start_image (in_tuser),
    .cfg         (cfg),
    .pix_valid   (dec_valid),
    .pix         (dec_pix)
  );

  // load a pixel only on the byte transaction that completes it
  tga_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_take && dec_valid),
    .pix_in    (dec_pix),
    .out_ready (out_tready),
    .can_load  (in_tready),
    .out_valid (out_tvalid),
    .pix_out   (held_pix)
  );

  assign out_tdata = {held_pix.repeat_res, held_pix.alpha, held_pix.blue,
                      held_pix.green, held_pix.red};
  assign out_tlast = held_pix.last;
  assign out_tuser = held_pix.over;

endmodule

`default_nettype wire

// ----- rtl/tga_cfg.sv -----
// Configuration register file: pixel size, coding mode and pixel total.
`default_nettype none

module tga_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              wr_en,
  input  wire logic [tga_pkg::CFG_IDX_W-1:0]     wr_idx,
  input  wire logic [tga_pkg::CFG_TOTAL_W-1:0]   wr_data,
  output tga_pkg::cfg_t                          cfg
);

  tga_pkg::cfg_t cfg_r;
  tga_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (tga_pkg::cfg_reg_t'(wr_idx))
        tga_pkg::REG_BPP:   cfg_nxt.bpp   = wr_data[tga_pkg::CFG_BPP_W-1:0];
        tga_pkg::REG_RLE:   cfg_nxt.rle   = wr_data[0];
        tga_pkg::REG_TOTAL: cfg_nxt.total = wr_data;
        default:            cfg_nxt       = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bpp   <= tga_pkg::BPP_RESET;
      cfg_r.rle   <= 1'b1;
      cfg_r.total <= tga_pkg::CFG_TOTAL_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- rtl/tga_dec.sv -----
// Byte decoder: packet header parsing, pixel assembly and image end tracking.
`default_nettype none

module tga_dec #(
  parameter int PIXEL_COUNT_BITS = tga_pkg::PIXEL_COUNT_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          take,
  input  wire logic [7:0]    data_byte,
  input  wire logic          start_image,
  input  wire tga_pkg::cfg_t cfg,
  output logic               pix_valid,
  output tga_pkg::pix_t      pix
);

  localparam int W = PIXEL_COUNT_BITS;

  logic [2:0]   phase_r, phase_nxt;
  logic         is_run_r, is_run_nxt;
  logic [7:0]   left_r, left_nxt;
  logic [7:0]   blue_r, blue_nxt;
  logic [7:0]   green_r, green_nxt;
  logic [7:0]   red_r, red_nxt;
  logic [W-1:0] done_cnt_r, done_cnt_nxt;
  logic         img_done_r, img_done_nxt;

  logic [2:0]      phase_c;
  logic            is_run_c;
  logic [7:0]      left_c;
  logic [W-1:0]    done_c;
  logic            img_done_c;
  logic [2:0]      size;
  logic [7:0]      alpha;
  logic [7:0]      rep;
  logic            over;
  logic            last;
  logic [W+23:0]   total_ext;
  logic [W-1:0]    total_c;
  logic [W-1:0]    pix_left;
  logic [W+7:0]    rep_wide;
  logic [W-1:0]    rep_ext;

  always_comb begin
    // start of image clears the decoder before this byte is taken
    phase_c    = start_image ? 3'd0 : phase_r;
    is_run_c   = start_image ? 1'b0 : is_run_r;
    left_c     = start_image ? 8'd0 : left_r;
    done_c     = start_image ? '0 : done_cnt_r;
    img_done_c = start_image ? 1'b0 : img_done_r;

    phase_nxt    = phase_c;
    is_run_nxt   = is_run_c;
    left_nxt     = left_c;
    blue_nxt     = blue_r;
    green_nxt    = green_r;
    red_nxt      = red_r;
    done_cnt_nxt = done_c;
    img_done_nxt = img_done_c;

    pix_valid = 1'b0;
    size      = (cfg.bpp == tga_pkg::BPP_ALPHA) ? tga_pkg::SIZE_RGBA : tga_pkg::SIZE_RGB;
    alpha     = 8'd0;
    rep       = 8'd1;
    over      = 1'b0;
    last      = 1'b0;
    rep_wide  = '0;
    rep_ext   = '0;

    total_ext = {{W{1'b0}}, cfg.total};
    total_c   = total_ext[W-1:0];
    if (total_c == '0) total_c = W'(1);
    pix_left  = (total_c > done_c) ? (total_c - done_c) : '0;

    if (img_done_c) begin
      // hold everything until the next image
    end else if (cfg.rle && left_c == 8'd0) begin
      // packet header
      if ((data_byte & tga_pkg::RUN_FLAG) != 8'd0) begin
        is_run_nxt = 1'b1;
        left_nxt   = data_byte - tga_pkg::RUN_BIAS;
      end else begin
        is_run_nxt = 1'b0;
        left_nxt   = data_byte + 8'd1;
      end
      phase_nxt = 3'd0;
    end else begin
      case (phase_c)
        3'd0:    blue_nxt  = data_byte;
        3'd1:    green_nxt = data_byte;
        3'd2:    red_nxt   = data_byte;
        default: alpha     = (size == tga_pkg::SIZE_RGBA) ? data_byte : 8'd0;
      endcase

      if ((phase_c + 3'd1) < size) begin
        phase_nxt = phase_c + 3'd1;
      end else begin
        phase_nxt = 3'd0;
        pix_valid = 1'b1;

        if (cfg.rle && is_run_c) begin
          rep      = left_c;
          left_nxt = 8'd0;
        end else begin
          rep = 8'd1;
          if (cfg.rle) left_nxt = left_c - 8'd1;
        end

        // clip at the image end
        rep_wide = {{W{1'b0}}, rep};
        rep_ext  = rep_wide[W-1:0];
        if (rep_ext > pix_left) begin
          rep  = (pix_left == '0) ? 8'd1 : pix_left[7:0];
          over = 1'b1;
        end
        rep_wide     = {{W{1'b0}}, rep};
        rep_ext      = rep_wide[W-1:0];
        done_cnt_nxt = done_c + rep_ext;
        last         = over || (rep_ext >= pix_left);

        if (last) begin
          if (cfg.rle && left_nxt != 8'd0) over = 1'b1;
          img_done_nxt = 1'b1;
          left_nxt     = 8'd0;
          is_run_nxt   = 1'b0;
        end
      end
    end

    pix.red        = red_nxt;
    pix.green      = green_nxt;
    pix.blue       = blue_nxt;
    pix.alpha      = alpha;
    pix.repeat_res = rep;
    pix.last       = last;
    pix.over       = over;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= 3'd0;
      is_run_r   <= 1'b0;
      left_r     <= 8'd0;
      done_cnt_r <= '0;
      img_done_r <= 1'b0;
    end else if (take) begin
      phase_r    <= phase_nxt;
      is_run_r   <= is_run_nxt;
      left_r     <= left_nxt;
      done_cnt_r <= done_cnt_nxt;
      img_done_r <= img_done_nxt;
    end
  end

  // each pixel writes all three color latches before it is given
  always_ff @(posedge clk) begin
    if (take) begin
      blue_r  <= blue_nxt;
      green_r <= green_nxt;
      red_r   <= red_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tga_obuf.sv -----
// Output register: holds one decoded pixel until the receiver takes it.
`default_nettype none

module tga_obuf (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,
  input  wire tga_pkg::pix_t pix_in,
  input  wire logic          out_ready,
  output logic               can_load,
  output logic               out_valid,
  output tga_pkg::pix_t      pix_out
);

  logic          valid_r, valid_nxt;
  tga_pkg::pix_t pix_r;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load)           valid_nxt = 1'b1;
    else if (out_ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix_r <= pix_in;
    end
  end

  assign out_valid = valid_r;
  assign pix_out   = pix_r;

endmodule

`default_nettype wire

// ----- bench/tga_rle_pixel_decoder_unit_tb.sv -----
// Testbench of the TGA run-length pixel decoder: directed table, then random images, all self-checked.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_unit_tb;
  import tga_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int BYTE_GOAL     = 1850;
  localparam int SETTLE_CYCLES = 4;   // output register latency plus margin
  localparam int DRAIN_LIMIT   = 20000;

  typedef enum logic {ROW_WRITE, ROW_BYTE} row_kind_t;

  // One step of the directed plan: a register write or one byte, with an
  // optional hand-typed pixel that the byte must produce.
  typedef struct packed {
    row_kind_t              kind;
    cfg_reg_t               idx;
    logic [CFG_TOTAL_W-1:0] val;
    logic [7:0]             b;
    logic                   s;
    logic                   typed_ok;
    pix_t                   typed;
  } plan_row_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata  = '0;   // [7:0] data_byte
  logic                   in_tuser  = 1'b0; // [0] start_image
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [39:0]            out_tdata;        // red, green, blue, alpha, repeat_res
  logic                   out_tlast;        // last_pixel
  logic                   out_tuser;        // [0] overrun
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_TOTAL_W-1:0] cfg_data  = '0;

  tga_rle_pixel_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Register copies held by the bench
  logic [CFG_BPP_W-1:0]   px_size_sel;
  logic                   rle_on;
  logic [CFG_TOTAL_W-1:0] pix_total;

  // Decoder state as the bench tracks it
  logic [2:0]                      comp_idx;
  logic                            in_run;
  logic [7:0]                      pkt_pixels;
  logic [7:0]                      blue_q, green_q, red_q;
  logic [PIXEL_COUNT_BITS_DEF-1:0] pix_count;
  logic                            img_done;

  pix_t      pending_pixels[$];
  plan_row_t plan[$];

  int   errors     = 0;
  int   bytes_fed  = 0;
  int   cycles     = 0;
  int   stall_left = 0;
  int   recv_gap;
  logic calm = 1'b0;   // suppress idling on both sides
  logic lead = 1'b0;   // next byte opens an image

  // ---------------------------------------------------------------------
  // Pixel predictor
  // ---------------------------------------------------------------------
  task automatic clear_decoder();
    comp_idx   = '0;
    in_run     = 1'b0;
    pkt_pixels = '0;
    blue_q     = '0;
    green_q    = '0;
    red_q      = '0;
    pix_count  = '0;
    img_done   = 1'b0;
  endtask

  // Advance the tracked state by one accepted byte; hit says a pixel is due.
  task automatic decode_byte(input logic [7:0] b, input logic s,
                             output logic hit, output pix_t p);
    int unsigned size, rep, tot, remain;
    logic [7:0]  a;
    logic        ovf, fin;
    hit = 1'b0;
    p   = '0;
    if (s) clear_decoder();
    // Hold everything once the image is complete
    if (img_done) return;
    // Packet header: run of (b - 127) or b + 1 literal pixels
    if (rle_on && pkt_pixels == 8'd0) begin
      in_run     = (b & RUN_FLAG) != 8'h00;
      pkt_pixels = in_run ? b - RUN_BIAS : b + 8'd1;
      comp_idx   = '0;
      return;
    end
    size = (px_size_sel == BPP_ALPHA) ? 4 : 3;
    a    = '0;
    case (comp_idx)
      3'd0: blue_q = b;
      3'd1: green_q = b;
      3'd2: red_q = b;
      default: if (size == 4) a = b;
    endcase
    if ({29'd0, comp_idx} + 32'd1 < size) begin
      comp_idx = comp_idx + 3'd1;
      return;
    end
    comp_idx = '0;
    if (rle_on && in_run) begin
      rep        = {24'd0, pkt_pixels};
      pkt_pixels = '0;
    end else begin
      rep = 1;
      if (rle_on) pkt_pixels = pkt_pixels - 8'd1;
    end
    // Clip at the image end; a zero total counts as one pixel
    tot    = (pix_total == '0) ? 32'd1 : {8'd0, pix_total};
    remain = (tot > {8'd0, pix_count}) ? tot - {8'd0, pix_count} : 32'd0;
    ovf    = 1'b0;
    if (rep > remain) begin
      rep = (remain == 0) ? 32'd1 : remain;
      ovf = 1'b1;
    end
    pix_count = pix_count + rep[PIXEL_COUNT_BITS_DEF-1:0];
    fin       = ovf || rep >= remain;
    if (fin) begin
      if (rle_on && pkt_pixels != 8'd0) ovf = 1'b1;
      img_done   = 1'b1;
      pkt_pixels = '0;
      in_run     = 1'b0;
    end
    hit          = 1'b1;
    p.red        = red_q;
    p.green      = green_q;
    p.blue       = blue_q;
    p.alpha      = a;
    p.repeat_res = rep[7:0];
    p.last       = fin;
    p.over       = ovf;
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic check_pixel(input pix_t got, input pix_t want);
    if (got.red != want.red) report_mismatch("red", got.red, want.red);
    if (got.green != want.green) report_mismatch("green", got.green, want.green);
    if (got.blue != want.blue) report_mismatch("blue", got.blue, want.blue);
    if (got.alpha != want.alpha) report_mismatch("alpha", got.alpha, want.alpha);
    if (got.repeat_res != want.repeat_res)
      report_mismatch("repeat_res", got.repeat_res, want.repeat_res);
    if (got.last != want.last) report_mismatch("last_pixel", got.last, want.last);
    if (got.over != want.over) report_mismatch("overrun", got.over, want.over);
  endtask

  // Compare every pixel transaction with the oldest pending pixel
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0)
        report_mismatch("pixel with none pending", out_tdata[31:0], 0);
      else
        check_pixel(pix_t'({out_tuser, out_tlast, out_tdata}), pending_pixels.pop_front());
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tga_rle_pixel_decoder_unit_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Pacing: mostly no gap, some short ones, a few long ones
  // ---------------------------------------------------------------------
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Stall the result side at random
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      recv_gap = idle_gap();
      out_tready <= (recv_gap == 0);
      if (recv_gap > 0) stall_left <= recv_gap - 1;
    end
  end

  function automatic logic [CFG_TOTAL_W-1:0] rand_bpp();
    if ($urandom_range(0, 9) == 0) return CFG_TOTAL_W'($urandom_range(0, 7));
    return $urandom_range(0, 1) ? CFG_TOTAL_W'(BPP_ALPHA) : CFG_TOTAL_W'(BPP_RESET);
  endfunction

  function automatic logic [CFG_TOTAL_W-1:0] rand_total();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return CFG_TOTAL_W'($urandom_range(1000, 16777215));
    if (r < 6) return CFG_TOTAL_W'($urandom_range(1, 3));
    return CFG_TOTAL_W'($urandom_range(4, 40));
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  // Offer one byte, wait for the transaction, then log the pixel it owes.
  task automatic push_byte(input logic [7:0] b, input logic s,
                           input logic typed_ok, input pix_t typed);
    int   gap;
    logic hit, skipped;
    pix_t p;
    gap = idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    skipped = img_done && !s;
    decode_byte(b, s, hit, p);
    if (typed_ok) pending_pixels.push_back(typed);
    else if (hit) pending_pixels.push_back(p);
    if (!skipped) bytes_fed++;
  endtask

  // Hold the sender until every pending pixel is out and the pipe is quiet
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_TOTAL_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BPP:   px_size_sel = val[CFG_BPP_W-1:0];
      REG_RLE:   rle_on = val[0];
      REG_TOTAL: pix_total = val;
      default: ;
    endcase
  endtask

  // Random-phase byte: now and then rewrite a register mid-image, drain the
  // pipe, or restart the image on a stray start flag.
  task automatic emit(input logic [7:0] b, input logic s);
    int r;
    r = $urandom_range(0, 999);
    if (r < 4) write_reg(REG_BPP, rand_bpp());
    else if (r < 7) write_reg(REG_RLE, CFG_TOTAL_W'($urandom_range(0, 1)));
    else if (r < 10) write_reg(REG_TOTAL, rand_total());
    else if (r < 16) drain();
    push_byte(b, s || lead || r >= 997, 1'b0, '0);
    lead = 1'b0;
  endtask

  task automatic send_pixel();
    int n;
    n = (px_size_sel == BPP_ALPHA) ? 4 : 3;
    repeat (n) emit(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // ---------------------------------------------------------------------
  // Directed plan builders
  // ---------------------------------------------------------------------
  function automatic void plan_write(input cfg_reg_t idx, input logic [CFG_TOTAL_W-1:0] val);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.val  = val;
    plan.push_back(row);
  endfunction

  function automatic void plan_byte(input logic [7:0] b, input logic s);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_BYTE;
    row.b    = b;
    row.s    = s;
    plan.push_back(row);
  endfunction

  // Byte that completes a pixel whose fields are typed in
  function automatic void plan_pixel(input logic [7:0] b, input logic s,
                                     input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] bl, input logic [7:0] a,
                                     input logic [7:0] rep, input logic last,
                                     input logic over);
    plan_row_t row;
    row                  = '0;
    row.kind             = ROW_BYTE;
    row.b                = b;
    row.s                = s;
    row.typed_ok         = 1'b1;
    row.typed.red        = r;
    row.typed.green      = g;
    row.typed.blue       = bl;
    row.typed.alpha      = a;
    row.typed.repeat_res = rep;
    row.typed.last       = last;
    row.typed.over       = over;
    plan.push_back(row);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int cnt, stop_at, k;

    px_size_sel = BPP_RESET;
    rle_on      = 1'b1;
    pix_total   = 24'd1;
    clear_decoder();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Unmapped index must leave every register alone
    plan_write(REG_NONE, 24'h5A5A5A);
    // Reset defaults: one-pixel run of black completes a one-pixel image
    plan_byte(8'h80, 1'b1);
    plan_byte(8'h00, 1'b0);
    plan_byte(8'h00, 1'b0);
    plan_pixel(8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'd1, 1'b1, 1'b0);
    // Byte after the image end: dropped
    plan_byte(8'h55, 1'b0);
    // Longest run, four-byte pixels, largest total
    plan_write(REG_TOTAL, 24'hFFFFFF);
    plan_write(REG_BPP, 24'(BPP_ALPHA));
    plan_byte(8'hFF, 1'b1);
    plan_byte(8'h11, 1'b0);
    plan_byte(8'h22, 1'b0);
    plan_byte(8'h33, 1'b0);
    plan_pixel(8'hFF, 1'b0, 8'h33, 8'h22, 8'h11, 8'hFF, 8'd128, 1'b0, 1'b0);
    // Total lowered below the pixels already given
    plan_write(REG_TOTAL, 24'd2);
    plan_byte(8'h00, 1'b0);
    plan_byte(8'hFE, 1'b0);
    plan_byte(8'h01, 1'b0);
    plan_byte(8'h80, 1'b0);
    plan_pixel(8'h7F, 1'b0, 8'h80, 8'h01, 8'hFE, 8'h7F, 8'd1, 1'b1, 1'b1);
    // Zero total acts as one: a run of two is clipped
    plan_write(REG_TOTAL, 24'd0);
    plan_write(REG_BPP, 24'(BPP_RESET));
    plan_byte(8'h81, 1'b1);
    plan_byte(8'h0F, 1'b0);
    plan_byte(8'hF0, 1'b0);
    plan_pixel(8'hAA, 1'b0, 8'hAA, 8'hF0, 8'h0F, 8'h00, 8'd1, 1'b1, 1'b1);
    // Literal packet reaching past the image end
    plan_write(REG_TOTAL, 24'd1);
    plan_byte(8'h01, 1'b1);
    plan_byte(8'h01, 1'b0);
    plan_byte(8'h02, 1'b0);
    plan_pixel(8'h04, 1'b0, 8'h04, 8'h02, 8'h01, 8'h00, 8'd1, 1'b1, 1'b0 | 1'b1);
    // Raw mode inside a run packet, with the pixel size cut mid-pixel;
    // back in run-length mode the pending run of four closes the image.
    plan_write(REG_TOTAL, 24'd5);
    plan_byte(8'h83, 1'b1);
    plan_write(REG_RLE, 24'd0);
    plan_write(REG_BPP, 24'(BPP_ALPHA));
    plan_byte(8'hC0, 1'b0);
    plan_byte(8'hC1, 1'b0);
    plan_write(REG_BPP, 24'(BPP_RESET));
    plan_pixel(8'hC2, 1'b0, 8'hC2, 8'hC1, 8'hC0, 8'h00, 8'd1, 1'b0, 1'b0);
    plan_write(REG_RLE, 24'd1);
    plan_byte(8'hD0, 1'b0);
    plan_byte(8'hD1, 1'b0);
    plan_byte(8'hD2, 1'b0);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) write_reg(plan[i].idx, plan[i].val);
      else push_byte(plan[i].b, plan[i].s, plan[i].typed_ok, plan[i].typed);
    end

    // Hold off until the directed pixels are all out
    drain();

    // Random images: mostly well-formed packet streams, some pure noise
    while (bytes_fed < BYTE_GOAL) begin
      calm = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 1)) write_reg(REG_BPP, rand_bpp());
      if ($urandom_range(0, 3) == 0) write_reg(REG_RLE, CFG_TOTAL_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) write_reg(REG_TOTAL, rand_total());
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 30))
          emit(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      end else begin
        lead    = 1'b1;
        stop_at = bytes_fed + 400;
        while (lead || (!img_done && bytes_fed < stop_at)) begin
          if (rle_on) begin
            cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
            if ($urandom_range(0, 1)) begin
              emit(RUN_FLAG | 8'(cnt - 1), 1'b0);
              send_pixel();
            end else begin
              emit(8'(cnt - 1), 1'b0);
              repeat (cnt) if (!img_done) send_pixel();
            end
          end else begin
            send_pixel();
          end
        end
        // Trailing bytes past the image end
        repeat ($urandom_range(0, 3)) emit(8'($urandom_range(0, 255)), 1'b0);
      end
    end

    calm = 1'b0;
    in_tvalid <= 1'b0;
    for (k = 0; k < DRAIN_LIMIT && pending_pixels.size() != 0; k++) @(posedge clk);
    if (pending_pixels.size() != 0)
      report_mismatch("pixels never delivered", pending_pixels.size(), 0);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (errors == 0) begin
      $display("tga_rle_pixel_decoder_unit_tb OK");
    end else begin
      $display("tga_rle_pixel_decoder_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
